>>> hdl/bpq_pkg.sv
// Shared types, default sizes, command and result status codes for the bucketed priority queue.
package bpq_pkg;

  localparam int unsigned DefWaitPoints   = 16;
  localparam int unsigned DefSlotsPerPoint = 16;

  localparam int unsigned IdW   = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned RankW = 16;
  localparam int unsigned WpW   = 4;
  localparam int unsigned StatW = 2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]          passenger;
    logic [IdW-1:0]          destination;
    logic [TimeW-1:0]        arr_time;
    logic signed [RankW-1:0] rank;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

>>> hdl/bpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/bucketed_priority_queue_unit.sv
// Bucketed priority queue: per-point lists, enqueue append, best-entry dequeue with swap fill.
// An enqueue or a rejected command raises the result strobe once it has been checked;
// a dequeue of a non-empty list first scans it, one slot per cycle, then raises the strobe.
// Only one command is handled at a time: a new start is taken only while idle.
// Reset (synchronous, rst_n low) empties every list; entry storage is not cleared.
// The result strobe lasts one cycle and cannot be held off; busy falls as it rises.
module bucketed_priority_queue_unit #(
  parameter int unsigned WAIT_POINTS     = bpq_pkg::DefWaitPoints,
  parameter int unsigned SLOTS_PER_POINT = bpq_pkg::DefSlotsPerPoint
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [bpq_pkg::WpW-1:0]           in_waiting_point,
  input  logic [bpq_pkg::IdW-1:0]           in_passenger_id,
  input  logic [bpq_pkg::IdW-1:0]           in_destination_id,
  input  logic [bpq_pkg::TimeW-1:0]         in_arrival_time,
  input  logic signed [bpq_pkg::RankW-1:0]  in_rank,
  output logic                              out_valid,
  output logic [bpq_pkg::StatW-1:0]         out_status,
  output logic [bpq_pkg::IdW-1:0]           out_passenger,
  output logic [bpq_pkg::IdW-1:0]           out_destination,
  output logic [bpq_pkg::TimeW-1:0]         out_time,
  output logic signed [bpq_pkg::RankW-1:0]  out_rank
);

  import bpq_pkg::*;

  localparam int unsigned Depth = WAIT_POINTS * SLOTS_PER_POINT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PW    = (WAIT_POINTS > 1) ? $clog2(WAIT_POINTS) : 1;
  localparam int unsigned SW    = (SLOTS_PER_POINT > 1) ? $clog2(SLOTS_PER_POINT) : 1;
  localparam int unsigned CW    = $clog2(SLOTS_PER_POINT + 1);
  localparam int unsigned XW    = 9;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic          cmd_r;
  logic          wp_ok_r;
  logic [PW-1:0] wp_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] base_r;
  logic [CW-1:0] idx_r, idx_nxt;
  entry_t        in_entry_r;
  entry_t        best_r, best_nxt;
  logic [SW-1:0] best_slot_r, best_slot_nxt;

  logic [CW-1:0] fill_r [WAIT_POINTS];
  logic          fill_we;
  logic [CW-1:0] fill_wdata;

  logic          out_valid_r, out_valid_nxt;
  logic [StatW-1:0] out_status_r, out_status_nxt;
  entry_t        out_entry_r, out_entry_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  entry_t        cur;

  logic [XW-1:0] wp_ext;
  logic          accept;
  logic [CW-1:0] cur_slot;
  logic          better;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign wp_ext = XW'(in_waiting_point);
  assign cur    = entry_t'(ram_rdata);

  // shared entry storage for all lists
  bpq_ram #(
    .WIDTH (EntryW),
    .DEPTH (Depth)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // latch the command transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_cmd;
      wp_ok_r    <= (wp_ext < XW'(WAIT_POINTS));
      wp_r       <= wp_ext[PW-1:0];
      base_r     <= AW'(wp_ext) * AW'(SLOTS_PER_POINT);
      in_entry_r <= '{passenger: in_passenger_id, destination: in_destination_id,
                      arr_time: in_arrival_time, rank: in_rank};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count_r <= (wp_ext < XW'(WAIT_POINTS)) ? fill_r[wp_ext[PW-1:0]] : '0;
    end
  end

  // compare the entry just read against the best so far
  always_comb begin
    cur_slot = idx_r - CW'(1);
    better   = (idx_r == CW'(1)) || (cur.rank > best_r.rank) ||
               ((cur.rank == best_r.rank) && (cur.arr_time < best_r.arr_time));
    best_nxt      = better ? cur : best_r;
    best_slot_nxt = better ? cur_slot[SW-1:0] : best_slot_r;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    ram_we         = 1'b0;
    ram_waddr      = base_r + AW'(count_r[SW-1:0]);
    ram_wdata      = in_entry_r;
    ram_raddr      = base_r;
    fill_we        = 1'b0;
    fill_wdata     = count_r + CW'(1);
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_OK;
    out_entry_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cmd_r == CMD_ENQ) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (!wp_ok_r || (count_r >= CW'(SLOTS_PER_POINT))) begin
            out_status_nxt = STAT_FULL;
          end else begin
            ram_we  = 1'b1;
            fill_we = 1'b1;
          end
        end else if (!wp_ok_r || (count_r == '0)) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_EMPTY;
        end else begin
          ram_raddr = base_r;
          idx_nxt   = CW'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == count_r) begin
          // last entry in hand: return best, move last into its slot
          ram_we        = 1'b1;
          ram_waddr     = base_r + AW'(best_slot_nxt);
          ram_wdata     = cur;
          fill_we       = 1'b1;
          fill_wdata    = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          out_entry_nxt = best_nxt;
          state_nxt     = ST_IDLE;
        end else begin
          ram_raddr = base_r + AW'(idx_r[SW-1:0]);
          idx_nxt   = idx_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // list fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(WAIT_POINTS); i++) begin
        fill_r[i] <= '0;
      end
    end else if (fill_we) begin
      fill_r[wp_r] <= fill_wdata;
    end
  end

  // scan and result payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (state_r == ST_SCAN) begin
      best_r      <= best_nxt;
      best_slot_r <= best_slot_nxt;
    end
    if (out_valid_nxt) begin
      out_status_r <= out_status_nxt;
      out_entry_r  <= out_entry_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_passenger   = out_entry_r.passenger;
  assign out_destination = out_entry_r.destination;
  assign out_time        = out_entry_r.arr_time;
  assign out_rank        = out_entry_r.rank;

endmodule
